// File: hdl/rns_pkg.sv
// ----------------------------------------------------------------------------
// rns_pkg
// Shared types and constants for the fixed-radius neighbor search block.
// ----------------------------------------------------------------------------
package rns_pkg;

    // Field widths
    localparam int COORD_W    = 16;
    localparam int PIDX_W     = 16;
    localparam int SQ_W       = 32;
    localparam int DIST_W     = 34;
    localparam int CNT_W      = 17;

    // Point index limit; the index counter can hold the limit itself
    localparam int MAX_POINTS = 65536;
    localparam int IDX_W      = $clog2(MAX_POINTS + 1);

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_X  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_Y  = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_Z  = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS   = CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_HITS = CFG_ADDR_W'(4);

    localparam logic [CNT_W-1:0] MAX_HITS_RESET = CNT_W'(65536);

    // Stream widths
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 72;
    localparam int M_PAD_W    = M_TDATA_W - PIDX_W - DIST_W - CNT_W;

    // Result queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One result item
    typedef struct packed {
        logic               hit;
        logic [PIDX_W-1:0]  point_index;
        logic [DIST_W-1:0]  dist_sq;
        logic               done_res;
        logic [CNT_W-1:0]   found_count;
    } result_t;

endpackage

// File: hdl/radius_neighbor_search.sv
// ----------------------------------------------------------------------------
// radius_neighbor_search
// Fixed-radius neighbor search over a streamed point cloud.
// ----------------------------------------------------------------------------
// Takes one point per clock and sustains that rate when the result side keeps
// up. A point passes the stage A, B and C registers to the decision stage and,
// if it is a hit or the last point, is pushed into a four-entry queue; the
// output register then takes its result from the queue. When the queue is
// full and the decision stage holds a result, the whole front pipeline stalls
// and tready drops. The only loop from one point to the next is the index and
// hit counter update in the decision stage. Hits are reported with tuser high;
// the point marked tlast closes the search with tlast high on its result and
// found_count set. Write the query, radius and max_hits registers only while
// no search is in flight; a radius write reaches the compare via radius_sq_reg.
// ----------------------------------------------------------------------------
module radius_neighbor_search import rns_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // point stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // px[15:0], py[31:16], pz[47:32]
    input  logic                  s_axis_tlast,   // last
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // point_index[15:0], dist_sq[49:16],
                                                  // found_count[66:50], zero pad
    output logic                  m_axis_tuser,   // hit
    output logic                  m_axis_tlast    // done_res
);

    logic    push, push_ready, q_valid, q_pop;
    result_t push_data, q_data;

    rns_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_px       (s_axis_tdata[COORD_W-1:0]),
        .in_py       (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .in_pz       (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
        .in_last     (s_axis_tlast),
        .push        (push),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    rns_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_ready  (push_ready),
        .push_data   (push_data),
        .pop         (q_pop),
        .pop_valid   (q_valid),
        .pop_data    (q_data)
    );

    rns_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_data        (q_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: hdl/rns_front.sv
// ----------------------------------------------------------------------------
// rns_front
// Configuration registers, distance pipeline and hit classification.
// Four stages: abs difference, squares, sum and radius compare, decision.
// ----------------------------------------------------------------------------
module rns_front import rns_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // point stream
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_W-1:0]     in_px,
    input  logic [COORD_W-1:0]     in_py,
    input  logic [COORD_W-1:0]     in_pz,
    input  logic                   in_last,
    // result push into queue
    output logic                   push,
    input  logic                   push_ready,
    output result_t                push_data
);

    // configuration registers
    logic signed [COORD_W-1:0] query_x_reg, query_y_reg, query_z_reg;
    logic [COORD_W-1:0]        radius_reg;
    logic [SQ_W-1:0]           radius_sq_reg;
    logic [CNT_W-1:0]          max_hits_reg;

    // search counters
    logic [IDX_W-1:0] next_index_reg, next_index_next;
    logic [CNT_W-1:0] hit_count_reg,  hit_count_next;

    // stage A: absolute differences
    logic              va_reg, last_a_reg;
    logic [COORD_W-1:0] ax_reg, ay_reg, az_reg;
    // stage B: squares
    logic              vb_reg, last_b_reg;
    logic [SQ_W-1:0]   sx_reg, sy_reg, sz_reg;
    // stage C: sum and radius compare
    logic              vc_reg, last_c_reg, inside_c_reg;
    logic [DIST_W-1:0] d2_c_reg;

    logic               stage_en;
    logic [COORD_W-1:0] ax_next, ay_next, az_next;
    logic [DIST_W-1:0]  d2_next;
    logic               in_range, hit_d, emit_d;
    logic [CNT_W-1:0]   count_inc;

    // |p - q| as a 16-bit magnitude
    function automatic logic [COORD_W-1:0] abs_diff(
        input logic [COORD_W-1:0] p,
        input logic [COORD_W-1:0] q
    );
        logic [COORD_W:0] d;
        logic [COORD_W:0] m;
        d = {p[COORD_W-1], p} - {q[COORD_W-1], q};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[COORD_W-1:0];
    endfunction

    always_comb begin
        ax_next = abs_diff(in_px, query_x_reg);
        ay_next = abs_diff(in_py, query_y_reg);
        az_next = abs_diff(in_pz, query_z_reg);
        d2_next = DIST_W'(sx_reg) + DIST_W'(sy_reg) + DIST_W'(sz_reg);
    end

    // decision stage: index limit, hit limit, result emission
    always_comb begin
        in_range  = next_index_reg < IDX_W'(MAX_POINTS);
        hit_d     = vc_reg && in_range && inside_c_reg && (hit_count_reg < max_hits_reg);
        count_inc = hit_count_reg + CNT_W'(hit_d);
        emit_d    = vc_reg && (hit_d || last_c_reg);
        stage_en  = !emit_d || push_ready;
        push      = emit_d && push_ready;

        push_data.hit         = hit_d;
        push_data.point_index = hit_d ? next_index_reg[PIDX_W-1:0] : '0;
        push_data.dist_sq     = hit_d ? d2_c_reg : '0;
        push_data.done_res    = last_c_reg;
        push_data.found_count = last_c_reg ? count_inc : '0;

        next_index_next = next_index_reg;
        hit_count_next  = hit_count_reg;
        if (vc_reg && stage_en) begin
            if (last_c_reg) begin
                next_index_next = '0;
                hit_count_next  = '0;
            end else begin
                next_index_next = next_index_reg + IDX_W'(in_range);
                hit_count_next  = count_inc;
            end
        end
    end

    assign in_ready = stage_en;

    // control state, configuration and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_x_reg    <= '0;
            query_y_reg    <= '0;
            query_z_reg    <= '0;
            radius_reg     <= '0;
            radius_sq_reg  <= '0;
            max_hits_reg   <= MAX_HITS_RESET;
            next_index_reg <= '0;
            hit_count_reg  <= '0;
            va_reg         <= 1'b0;
            vb_reg         <= 1'b0;
            vc_reg         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_QUERY_X:  query_x_reg  <= cfg_wr_data[COORD_W-1:0];
                    CFG_QUERY_Y:  query_y_reg  <= cfg_wr_data[COORD_W-1:0];
                    CFG_QUERY_Z:  query_z_reg  <= cfg_wr_data[COORD_W-1:0];
                    CFG_RADIUS:   radius_reg   <= cfg_wr_data[COORD_W-1:0];
                    CFG_MAX_HITS: max_hits_reg <= cfg_wr_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            radius_sq_reg  <= radius_reg * radius_reg;
            next_index_reg <= next_index_next;
            hit_count_reg  <= hit_count_next;
            if (stage_en) begin
                va_reg <= in_valid;
                vb_reg <= va_reg;
                vc_reg <= vb_reg;
            end
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (stage_en) begin
            ax_reg       <= ax_next;
            ay_reg       <= ay_next;
            az_reg       <= az_next;
            last_a_reg   <= in_last;
            sx_reg       <= ax_reg * ax_reg;
            sy_reg       <= ay_reg * ay_reg;
            sz_reg       <= az_reg * az_reg;
            last_b_reg   <= last_a_reg;
            d2_c_reg     <= d2_next;
            inside_c_reg <= d2_next <= DIST_W'(radius_sq_reg);
            last_c_reg   <= last_b_reg;
        end
    end

endmodule

// File: hdl/rns_queue.sv
// ----------------------------------------------------------------------------
// rns_queue
// Small result queue that decouples classification from delivery.
// ----------------------------------------------------------------------------
module rns_queue import rns_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    output logic    push_ready,
    input  result_t push_data,
    input  logic    pop,
    output logic    pop_valid,
    output result_t pop_data
);

    localparam logic [QPTR_W:0] QUEUE_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

    result_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign push_ready = count_reg != QUEUE_FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
        end
    end

endmodule

// File: hdl/rns_back.sv
// ----------------------------------------------------------------------------
// rns_back
// Output register: takes results from the queue and presents them on the
// master stream.
// ----------------------------------------------------------------------------
module rns_back import rns_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  result_t              q_data,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tuser,
    output logic                 m_axis_tlast
);

    logic    out_valid_reg;
    result_t out_reg;

    assign q_pop = q_valid && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_axis_tready) begin
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= q_data;
        end
    end

    // tdata: point_index, dist_sq, found_count, zero pad
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_reg.found_count, out_reg.dist_sq,
                            out_reg.point_index};
    assign m_axis_tuser  = out_reg.hit;
    assign m_axis_tlast  = out_reg.done_res;

endmodule
